// File: src/ufmt_pkg.sv
// shared types and constants for the unsigned decimal field formatter
package ufmt_pkg;

    localparam int VALUE_W        = 64;
    localparam int FIELD_W        = 6;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int CNT_W          = $clog2(VALUE_W);
    localparam int MAX_WIDTH_DEF  = 40;
    localparam int MAX_DIGITS_DEF = 20;
    // most characters one number may produce
    localparam int MAX_RESULTS    = 60;

    // stream payload widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam logic [CHAR_W-1:0]  CHAR_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [DIGIT_W-1:0] DD_LIMIT   = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_ADJUST  = 4'd3;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_NORM,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SPACE,
        EMIT_DIGIT
    } emit_state_t;

    // format controls that travel with one number
    typedef struct packed {
        logic [FIELD_W-1:0] field_width;
        logic               precision_given;
        logic [FIELD_W-1:0] precision;
        logic [FIELD_W-1:0] zero_pads;
    } fmt_t;

endpackage

// File: src/ufmt_bcd_conv.sv
// bit-serial binary to bcd converter with leading zero strip
module ufmt_bcd_conv import ufmt_pkg::*; #(
    parameter  int MAX_DIGITS = MAX_DIGITS_DEF,
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1),
    localparam int BCD_W      = DIGIT_W * MAX_DIGITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    input  fmt_t               in_fmt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BCD_W-1:0]   out_digits,
    output logic [LEN_W-1:0]   out_len,
    output logic               out_nonzero,
    output fmt_t               out_fmt
);

    conv_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               nz_reg, nz_next;
    logic               ovf_reg, ovf_next;
    fmt_t               fmt_reg, fmt_next;
    logic [BCD_W-1:0]   adj;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DD_LIMIT) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DD_ADJUST;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        len_reg <= len_next;
        nz_reg  <= nz_next;
        ovf_reg <= ovf_next;
        fmt_reg <= fmt_next;
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        nz_next    = nz_reg;
        ovf_next   = ovf_reg;
        fmt_next   = fmt_reg;
        in_ready   = (state_reg == CONV_IDLE);
        out_valid  = (state_reg == CONV_DONE);
        unique case (state_reg)
            CONV_IDLE: begin
                if (in_valid) begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    nz_next    = |in_value;
                    ovf_next   = 1'b0;
                    fmt_next   = in_fmt;
                    state_next = CONV_SHIFT;
                end
            end
            CONV_SHIFT: begin
                bin_next = bin_reg << 1;
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                // a bit lost off the top digit means more digits than fit
                ovf_next = ovf_reg | adj[BCD_W-1];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    len_next   = LEN_W'(MAX_DIGITS);
                    state_next = CONV_NORM;
                end
            end
            CONV_NORM: begin
                // drop one leading zero digit a cycle, keep at least one;
                // a truncated value keeps all its low digits
                if (!ovf_reg && bcd_reg[BCD_W-1 -: DIGIT_W] == '0 && len_reg > LEN_W'(1)) begin
                    bcd_next = bcd_reg << DIGIT_W;
                    len_next = len_reg - 1'b1;
                end else begin
                    state_next = CONV_DONE;
                end
            end
            CONV_DONE: begin
                if (out_ready) begin
                    state_next = CONV_IDLE;
                end
            end
            default: state_next = CONV_IDLE;
        endcase
    end

    assign out_digits  = bcd_reg;
    assign out_len     = len_reg;
    assign out_nonzero = nz_reg;
    assign out_fmt     = fmt_reg;

endmodule

// File: src/ufmt_emit.sv
// space count and character emitter with output register
module ufmt_emit import ufmt_pkg::*; #(
    parameter  int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter  int MAX_DIGITS = MAX_DIGITS_DEF,
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1),
    localparam int BCD_W      = DIGIT_W * MAX_DIGITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BCD_W-1:0]  in_digits,
    input  logic [LEN_W-1:0]  in_len,
    input  logic              in_nonzero,
    input  fmt_t              in_fmt,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char,
    output logic              m_last
);

    localparam int SPC_W = $clog2(MAX_WIDTH + 1);
    localparam int SUB_W = FIELD_W + 1;
    localparam logic [FIELD_W-1:0] MAX_W_C = FIELD_W'(MAX_WIDTH);

    emit_state_t       state_reg, state_next;
    logic [SPC_W-1:0]  spc_reg, spc_next;
    logic [LEN_W-1:0]  dcnt_reg, dcnt_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic [FIELD_W-1:0] wsat;
    logic [SUB_W-1:0]   sub;
    logic [SUB_W-1:0]   wext;
    logic [SUB_W-1:0]   diff;
    logic [SUB_W-1:0]   room;
    logic [SPC_W-1:0]   spaces;
    logic               load_ok;

    // leading space count from the saturated width
    always_comb begin
        wsat = (in_fmt.field_width > MAX_W_C) ? MAX_W_C : in_fmt.field_width;
        wext = {1'b0, wsat};
        if (!in_fmt.precision_given) begin
            sub = SUB_W'(in_len);
        end else if (in_fmt.zero_pads != '0) begin
            sub = {1'b0, in_fmt.zero_pads} + SUB_W'(in_len);
        end else if (in_nonzero) begin
            sub = SUB_W'(in_len);
        end else begin
            sub = {1'b0, in_fmt.precision};
        end
        diff = wext - sub;
        // spaces plus digits never exceed the per-number character limit
        room = SUB_W'(MAX_RESULTS) - SUB_W'(in_len);
        if (wext > sub) begin
            spaces = (diff > room) ? SPC_W'(room) : SPC_W'(diff);
        end else begin
            spaces = '0;
        end
    end

    assign load_ok = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EMIT_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        spc_reg  <= spc_next;
        dcnt_reg <= dcnt_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        spc_next   = spc_reg;
        dcnt_next  = dcnt_reg;
        dig_next   = dig_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_ready;
        in_ready   = (state_reg == EMIT_IDLE);
        unique case (state_reg)
            EMIT_IDLE: begin
                if (in_valid) begin
                    dig_next   = in_digits;
                    dcnt_next  = in_len;
                    spc_next   = spaces;
                    state_next = (spaces != '0) ? EMIT_SPACE : EMIT_DIGIT;
                end
            end
            EMIT_SPACE: begin
                if (load_ok) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_SPACE;
                    last_next  = 1'b0;
                    spc_next   = spc_reg - 1'b1;
                    if (spc_reg == SPC_W'(1)) begin
                        state_next = EMIT_DIGIT;
                    end
                end
            end
            EMIT_DIGIT: begin
                if (load_ok) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + CHAR_W'(dig_reg[BCD_W-1 -: DIGIT_W]);
                    last_next  = (dcnt_reg == LEN_W'(1));
                    dig_next   = dig_reg << DIGIT_W;
                    dcnt_next  = dcnt_reg - 1'b1;
                    if (dcnt_reg == LEN_W'(1)) begin
                        state_next = EMIT_IDLE;
                    end
                end
            end
            default: state_next = EMIT_IDLE;
        endcase
    end

    assign m_valid = valid_reg;
    assign m_char  = char_reg;
    assign m_last  = last_reg;

endmodule

// File: src/unsigned_decimal_field_formatter.sv
// top level of the unsigned decimal field formatter
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | one number with its format controls
//  m_axis  | out | m_axis_tvalid/tready   | one ascii character per beat, tlast on end
//
// a number is accepted, shifted bit-serially through the bcd converter, stripped of
// its leading zero digits (at least one digit stays) and handed off; the emitter
// then loads it and sends one beat per character (spaces plus digits); the
// converter works on the next number while the emitter drains the current one
// reset is synchronous, active low, and clears only control state
// a stalled m_axis holds the output register and backs up into the converter
module unsigned_decimal_field_formatter import ufmt_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // value[63:0], field_width[69:64], precision[75:70], zero_pads[81:76], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // precision_given[0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_char[5:0], zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int LEN_W = $clog2(MAX_DIGITS + 1);
    localparam int BCD_W = DIGIT_W * MAX_DIGITS;

    // input beat unpacking
    logic [VALUE_W-1:0] in_value;
    fmt_t               in_fmt;

    assign in_value              = s_axis_tdata[VALUE_W-1:0];
    assign in_fmt.field_width    = s_axis_tdata[VALUE_W +: FIELD_W];
    assign in_fmt.precision      = s_axis_tdata[VALUE_W + FIELD_W +: FIELD_W];
    assign in_fmt.zero_pads      = s_axis_tdata[VALUE_W + 2*FIELD_W +: FIELD_W];
    assign in_fmt.precision_given = s_axis_tuser[0];

    // converter to emitter handoff
    logic             conv_valid;
    logic             emit_ready;
    logic [BCD_W-1:0] conv_digits;
    logic [LEN_W-1:0] conv_len;
    logic             conv_nonzero;
    fmt_t             conv_fmt;
    logic [CHAR_W-1:0] out_char;

    ufmt_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_value    (in_value),
        .in_fmt      (in_fmt),
        .out_valid   (conv_valid),
        .out_ready   (emit_ready),
        .out_digits  (conv_digits),
        .out_len     (conv_len),
        .out_nonzero (conv_nonzero),
        .out_fmt     (conv_fmt)
    );

    ufmt_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (conv_valid),
        .in_ready   (emit_ready),
        .in_digits  (conv_digits),
        .in_len     (conv_len),
        .in_nonzero (conv_nonzero),
        .in_fmt     (conv_fmt),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_char     (out_char),
        .m_last     (m_axis_tlast)
    );

    // output beat packing
    assign m_axis_tdata = {{(M_TDATA_W - CHAR_W){1'b0}}, out_char};

endmodule
